// ----- sv/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that prop holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that cons holds in the same cycle as ante.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- sv/rrbs_pkg.sv -----
`timescale 1ns / 1ps

package rrbs_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_FIRST_PAGE      = 3'd0;
    localparam logic [2:0] REG_PAGE_COUNT      = 3'd1;
    localparam logic [2:0] REG_START_COLUMN    = 3'd2;
    localparam logic [2:0] REG_COLUMNS_PER_ROW = 3'd3;
    localparam logic [2:0] REG_FLIP_COLUMNS    = 3'd4;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;

    // Reset values of the registers
    localparam logic [2:0] FIRST_PAGE_RST      = 3'd0;
    localparam logic [3:0] PAGE_COUNT_RST      = 4'd8;
    localparam logic [6:0] START_COLUMN_RST    = 7'd0;
    localparam logic [7:0] COLUMNS_PER_ROW_RST = 8'd64;
    localparam logic       FLIP_COLUMNS_RST    = 1'b1;

    // Stream codes
    localparam logic       OP_START     = 1'b0;
    localparam logic       OP_BYTE      = 1'b1;
    localparam logic [7:0] MARK_ZERO    = 8'h00;
    localparam logic [7:0] MARK_ONES    = 8'hFF;
    localparam logic [3:0] LAST_PAGE    = 4'd15;
    localparam logic [7:0] FLIP_OFFSET  = 8'd4;

    localparam int OUT_TDATA_W = 32;

    typedef struct packed {
        logic       region_done;
        logic [8:0] byte_count;
        logic [7:0] fill_byte;
        logic [7:0] column_address;
        logic [2:0] page;
        logic       set_address;
    } t_result;

endpackage

// ----- sv/rle_region_blit_sequencer.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Channel   | Dir | Handshake          | Payload
// ----------+-----+--------------------+---------------------------------------------
// s_*       | in  | s_tvalid/s_tready  | s_tuser: operation, s_tdata: data_byte
// m_*       | out | m_tvalid/m_tready  | m_tdata: result fields, m_tlast: last
// i_cfg_*   | in  | i_cfg_we           | i_cfg_index, i_cfg_data (no read-back)
//
// Steps: an item is taken in S_IDLE (a start item then goes to S_START), then
// S_ROOM and S_SEG run for every row the item's columns touch, plus S_ADDR for
// a trailing row address. All row math runs through one shared 10-bit
// subtractor stepped by the sequencer.
// Reset: i_rst_n is synchronous, active low; all but the payload registers
// return to their defaults, the region goes idle. No clearing pass.
// Stalls: a result holds in the output register until transferred; the
// sequencer waits on a full output register, and s_tready is low while busy.

module rle_region_blit_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] operation
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [rrbs_pkg::OUT_TDATA_W-1:0] m_tdata,
    // [0] set_address, [3:1] page, [11:4] column_address, [19:12] fill_byte,
    // [28:20] byte_count, [29] region_done, [31:30] zero
    output logic        m_tlast,
    // configuration writes
    input  logic                               i_cfg_we,
    input  logic [rrbs_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [rrbs_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_ROOM  = 3'd2;
    localparam logic [2:0] S_SEG   = 3'd3;
    localparam logic [2:0] S_ADDR  = 3'd4;

    // configuration
    logic [2:0] r_first_page;
    logic [3:0] r_page_count;
    logic [6:0] r_start_column;
    logic [7:0] r_columns_per_row;
    logic       r_flip_columns;

    // sequencer state
    logic [2:0] r_state, n_state;
    logic [3:0] r_page, n_page;
    logic [7:0] r_col_idx, n_col_idx;
    logic       r_await, n_await;
    logic [7:0] r_run_value, n_run_value;
    logic       r_active, n_active;
    logic [7:0] r_remain, n_remain;     // columns still to place for this item
    logic [7:0] r_value, n_value;       // fill value for this item
    logic       r_emitted, n_emitted;   // a result already went out for this item
    logic [8:0] r_room, n_room;         // free columns left in the row

    // output register
    logic       r_out_valid, n_out_valid;
    rrbs_pkg::t_result r_out, n_out;
    logic       r_out_last, n_out_last;

    logic       out_free;
    logic       in_xfer;
    logic [8:0] limit;
    logic [9:0] sub_a, sub_b, sub_y;
    logic       borrow;
    logic [4:0] end_sum;
    logic [4:0] end_page;
    logic       on_last_page;
    logic [7:0] col_addr;
    logic [7:0] take;
    logic       row_full;

    assign s_tready = (r_state == S_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !r_out_valid || m_tready;

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {{(rrbs_pkg::OUT_TDATA_W - $bits(rrbs_pkg::t_result)){1'b0}}, r_out};
    assign m_tlast  = r_out_last;

    // 0 columns per row stands for a full 256-column row
    assign limit = {(r_columns_per_row == 8'd0), r_columns_per_row};

    // Shared subtractor: row room in S_ROOM, remaining minus room in S_SEG
    always_comb begin
        sub_a = {1'b0, limit};
        sub_b = {2'b00, r_col_idx};
        if (r_state == S_SEG) begin
            sub_a = {2'b00, r_remain};
            sub_b = {1'b0, r_room};
        end
    end
    assign sub_y  = sub_a - sub_b;
    assign borrow = sub_y[9];

    // Region end page saturates at 15
    assign end_sum      = {2'b00, r_first_page} + {1'b0, r_page_count};
    assign end_page     = (end_sum > {1'b0, rrbs_pkg::LAST_PAGE}) ? {1'b0, rrbs_pkg::LAST_PAGE}
                                                                  : end_sum;
    assign on_last_page = ({1'b0, r_page} + 5'd1) >= end_page;

    assign col_addr = {1'b0, r_start_column}
                    + (r_flip_columns ? rrbs_pkg::FLIP_OFFSET : 8'd0);

    // In S_SEG: the row fills unless fewer columns remain than the room
    assign row_full = !borrow;
    assign take     = row_full ? r_room[7:0] : r_remain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_page      <= rrbs_pkg::FIRST_PAGE_RST;
            r_page_count      <= rrbs_pkg::PAGE_COUNT_RST;
            r_start_column    <= rrbs_pkg::START_COLUMN_RST;
            r_columns_per_row <= rrbs_pkg::COLUMNS_PER_ROW_RST;
            r_flip_columns    <= rrbs_pkg::FLIP_COLUMNS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rrbs_pkg::REG_FIRST_PAGE:      r_first_page      <= i_cfg_data[2:0];
                rrbs_pkg::REG_PAGE_COUNT:      r_page_count      <= i_cfg_data[3:0];
                rrbs_pkg::REG_START_COLUMN:    r_start_column    <= i_cfg_data[6:0];
                rrbs_pkg::REG_COLUMNS_PER_ROW: r_columns_per_row <= i_cfg_data;
                rrbs_pkg::REG_FLIP_COLUMNS:    r_flip_columns    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state     = r_state;
        n_page      = r_page;
        n_col_idx   = r_col_idx;
        n_await     = r_await;
        n_run_value = r_run_value;
        n_active    = r_active;
        n_remain    = r_remain;
        n_value     = r_value;
        n_emitted   = r_emitted;
        n_room      = r_room;
        n_out_valid = r_out_valid && !m_tready;
        n_out       = r_out;
        n_out_last  = r_out_last;

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (s_tuser == rrbs_pkg::OP_START) begin
                        // restart: drop any region and pending marker
                        n_page      = {1'b0, r_first_page};
                        n_col_idx   = 8'd0;
                        n_await     = 1'b0;
                        n_run_value = 8'd0;
                        n_active    = (r_page_count != 4'd0);
                        n_state     = S_START;
                    end else if (r_active) begin
                        n_emitted = 1'b0;
                        if (r_await) begin
                            n_await  = 1'b0;
                            n_remain = s_tdata;
                            n_value  = r_run_value;
                            // a zero run count places nothing
                            if (s_tdata != 8'd0) begin
                                n_state = S_ROOM;
                            end
                        end else if (s_tdata == rrbs_pkg::MARK_ZERO ||
                                     s_tdata == rrbs_pkg::MARK_ONES) begin
                            n_await     = 1'b1;
                            n_run_value = s_tdata;
                        end else begin
                            n_remain = 8'd1;
                            n_value  = s_tdata;
                            n_state  = S_ROOM;
                        end
                    end
                end
            end
            S_START: begin
                if (out_free) begin
                    n_out_valid               = 1'b1;
                    n_out.set_address         = r_active;
                    n_out.page                = r_page[2:0];
                    n_out.column_address      = col_addr;
                    n_out.fill_byte           = 8'd0;
                    n_out.byte_count          = 9'd0;
                    n_out.region_done         = !r_active;
                    n_out_last                = 1'b1;
                    n_state                   = S_IDLE;
                end
            end
            S_ROOM: begin
                // a row shrunk below the index by a live write takes one column
                n_room  = (!borrow && sub_y[8:0] != 9'd0) ? sub_y[8:0] : 9'd1;
                n_state = S_SEG;
            end
            S_SEG: begin
                if (out_free) begin
                    n_out_valid          = 1'b1;
                    n_out.set_address    = r_emitted;
                    n_out.page           = r_page[2:0];
                    n_out.column_address = col_addr;
                    n_out.fill_byte      = r_value;
                    n_out.byte_count     = {take, 1'b0};
                    n_out.region_done    = row_full && on_last_page;
                    n_out_last           = !row_full || on_last_page;
                    n_emitted            = 1'b1;
                    if (!row_full) begin
                        n_col_idx = r_col_idx + take;
                        n_remain  = 8'd0;
                        n_state   = S_IDLE;
                    end else if (on_last_page) begin
                        // region ends; discard the rest of the run
                        n_col_idx = 8'd0;
                        n_active  = 1'b0;
                        n_remain  = 8'd0;
                        n_state   = S_IDLE;
                    end else begin
                        n_col_idx = 8'd0;
                        n_page    = r_page + 4'd1;
                        n_remain  = sub_y[7:0];
                        n_state   = (sub_y[7:0] == 8'd0) ? S_ADDR : S_ROOM;
                    end
                end
            end
            S_ADDR: begin
                // next row's address alone when the item has no columns left
                if (out_free) begin
                    n_out_valid          = 1'b1;
                    n_out.set_address    = 1'b1;
                    n_out.page           = r_page[2:0];
                    n_out.column_address = col_addr;
                    n_out.fill_byte      = 8'd0;
                    n_out.byte_count     = 9'd0;
                    n_out.region_done    = 1'b0;
                    n_out_last           = 1'b1;
                    n_state              = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_page      <= 4'd0;
            r_col_idx   <= 8'd0;
            r_await     <= 1'b0;
            r_run_value <= 8'd0;
            r_active    <= 1'b0;
            r_remain    <= 8'd0;
            r_emitted   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_page      <= n_page;
            r_col_idx   <= n_col_idx;
            r_await     <= n_await;
            r_run_value <= n_run_value;
            r_active    <= n_active;
            r_remain    <= n_remain;
            r_emitted   <= n_emitted;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_value    <= n_value;
        r_room     <= n_room;
        r_out      <= n_out;
        r_out_last <= n_out_last;
    end

    `ASSERT_IMPLIES(a_done_is_last, i_clk, i_rst_n, m_tvalid && r_out.region_done, m_tlast, "region end result not marked last")
    `ASSERT_IMPLIES(a_empty_has_meaning, i_clk, i_rst_n, m_tvalid && r_out.byte_count == 9'd0, r_out.set_address || r_out.region_done, "empty result carries neither address nor region end")
    `ASSERT_IMPLIES(a_work_nonzero, i_clk, i_rst_n, r_state == S_ROOM || r_state == S_SEG, r_remain != 8'd0 && r_active, "segment work with no columns or no region")
    `ASSERT_IMPLIES(a_room_nonzero, i_clk, i_rst_n, r_state == S_SEG, r_room != 9'd0, "row room is zero in segment step")

endmodule
